// File: rtl/bpfde_pkg.sv
// Shared types and constants for the band-packed frame store drawing engine.
// No dependencies.
package bpfde_pkg;

    localparam int COLUMNS_DEF = 160;
    localparam int BANDS = 6;
    localparam int ROW_MAX = 41;
    localparam int BAND_H = 7;

    typedef enum logic [2:0] {
        FN_FILL   = 3'd0,
        FN_SCROLL = 3'd1,
        FN_PIXEL  = 3'd2,
        FN_LINE   = 3'd3,
        FN_RECT   = 3'd4,
        FN_FRECT  = 3'd5,
        FN_READ   = 3'd6,
        FN_NONE   = 3'd7
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FILL,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_LINE_INIT,
        ST_LINE_STEP,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_OUT
    } state_t;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR_ADDR,
        OP_SWEEP_WR,
        OP_SCROLL_RD,
        OP_SCROLL_WR,
        OP_LINE_LOAD,
        OP_LINE_STEP,
        OP_PIX_RD,
        OP_PIX_WR,
        OP_READ_RD,
        OP_FRECT_LOAD
    } op_t;

    // When sweep_val is set, a sweep writes the fill byte chosen by the pen.
    typedef struct packed {
        op_t  op;
        logic sweep_val;
        logic [1:0] seg;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic scroll_last;
        logic line_done;
        logic frect_done;
        logic frect_empty;
    } stat_t;

endpackage

// File: rtl/bpfde_if.sv
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing.
interface bpfde_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bpfde_datapath.sv
// Frame store memory, address counters and the Bresenham stepper.
// Depends on bpfde_pkg.
module bpfde_datapath
    import bpfde_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output stat_t      stat,
    input  logic [2:0] func,
    input  logic [7:0] x_a,
    input  logic [7:0] y_a,
    input  logic [7:0] x_b,
    input  logic [7:0] y_b,
    input  logic       pen,
    output logic [7:0] rd_byte
);
    localparam int DEPTH = COLUMNS * BANDS;
    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [2:0] band_reg, band_next;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0] wr_data;
    logic we;
    logic rd_en;

    // Line walker state: 10-bit signed positions and error.
    logic signed [9:0] x_reg, y_reg, x2_reg, y2_reg;
    logic signed [9:0] dx_reg, dy_reg, err_reg;
    logic sx_reg, sy_reg;
    logic first_reg;       // first pixel of a line is the end point
    logic pen_reg;
    // Filled rectangle counters.
    logic [7:0] fx_reg, fy_reg;
    logic [8:0] pend_x_reg, pend_y_reg;

    logic [7:0] px, py;
    logic on_screen;
    logic [AW-1:0] pix_addr;
    logic [2:0] pbit;
    logic [2:0] pband;
    logic [7:0] band_base;

    always_comb
    begin
        // Band lookup by comparison; rows past the screen are never written.
        if (py >= 8'd35)
            pband = 3'd5;
        else if (py >= 8'd28)
            pband = 3'd4;
        else if (py >= 8'd21)
            pband = 3'd3;
        else if (py >= 8'd14)
            pband = 3'd2;
        else if (py >= 8'd7)
            pband = 3'd1;
        else
            pband = 3'd0;
        band_base = 8'(pband) * 8'(BAND_H);
        pbit = 3'(py - band_base);
        on_screen = (32'(px) < COLUMNS) && (py <= 8'(ROW_MAX));
        pix_addr = AW'(px) * AW'(BANDS) + AW'(pband);
    end

    // Segment endpoints for the rectangle outline.
    logic [7:0] s_x1, s_y1, s_x2, s_y2;
    always_comb
    begin
        s_x1 = x_a; s_y1 = y_a; s_x2 = x_b; s_y2 = y_b;
        if (func == FN_RECT)
        begin
            case (cmd.seg)
                2'd0: begin s_y2 = y_a; end
                2'd1: begin s_y1 = y_b; end
                2'd2: begin s_x2 = x_a; end
                default: begin s_x1 = x_b; end
            endcase
        end
    end

    logic signed [10:0] e2;
    logic stepx, stepy;
    always_comb
    begin
        e2 = {err_reg, 1'b0};
        stepx = e2 > -11'(dy_reg);
        stepy = e2 < 11'(dx_reg);
    end

    // Pixel coordinate currently addressed.
    always_comb
    begin
        if (func == FN_FRECT || func == FN_PIXEL)
        begin
            px = (func == FN_PIXEL) ? x_a : fx_reg;
            py = (func == FN_PIXEL) ? y_a : fy_reg;
        end
        else if (first_reg)
        begin
            px = x2_reg[7:0];
            py = y2_reg[7:0];
        end
        else
        begin
            px = x_reg[7:0];
            py = y_reg[7:0];
        end
    end

    logic pix_pen;
    assign pix_pen = (func == FN_PIXEL || func == FN_FRECT) ? pen_reg : 1'b0;

    // The read register only loads on a read, so a fetched word holds until used.
    assign rd_en = (cmd.op == OP_SCROLL_RD) || (cmd.op == OP_PIX_RD) || (cmd.op == OP_READ_RD);

    always_comb
    begin
        sweep_next = sweep_reg;
        band_next = band_reg;
        rd_addr = pix_addr;
        wr_addr = pix_addr;
        wr_data = q_reg;
        we = 1'b0;
        unique case (cmd.op)
            OP_CLEAR_ADDR:
            begin
                sweep_next = '0;
                band_next = '0;
            end
            OP_SWEEP_WR:
            begin
                we = 1'b1;
                wr_addr = sweep_reg;
                wr_data = (cmd.sweep_val && pen) ? 8'hFF : 8'h00;
                sweep_next = sweep_reg + AW'(1);
            end
            OP_SCROLL_RD:
            begin
                rd_addr = sweep_reg + AW'(1);
            end
            OP_SCROLL_WR:
            begin
                we = 1'b1;
                wr_addr = sweep_reg;
                wr_data = stat.scroll_last ? 8'h00 : q_reg;
                // last band of each column takes zero
                if (band_reg == 3'(BANDS - 1))
                begin
                    wr_data = 8'h00;
                    band_next = '0;
                end
                else
                    band_next = band_reg + 3'd1;
                sweep_next = sweep_reg + AW'(1);
            end
            OP_PIX_WR:
            begin
                we = on_screen;
                wr_data = pix_pen ? (q_reg & ~(8'd1 << pbit)) : (q_reg | (8'd1 << pbit));
            end
            OP_READ_RD: rd_addr = AW'(x_a) * AW'(BANDS) + AW'(y_a[2:0]);
            default: ;
        endcase
    end

    assign stat.sweep_last = (32'(sweep_reg) == DEPTH - 1);
    assign stat.scroll_last = (32'(sweep_reg) == DEPTH - 1);
    assign stat.line_done = !first_reg && x_reg == x2_reg && y_reg == y2_reg;
    assign stat.frect_done = (9'(fx_reg) == pend_x_reg) && (9'(fy_reg) == pend_y_reg);
    assign stat.frect_empty = (x_a > x_b) || (y_a > y_b);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            band_reg <= '0;
        end
        else
        begin
            sweep_reg <= sweep_next;
            band_reg <= band_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LINE_LOAD:
            begin
                x_reg <= 10'(s_x1);
                y_reg <= 10'(s_y1);
                x2_reg <= 10'(s_x2);
                y2_reg <= 10'(s_y2);
                dx_reg <= (s_x2 > s_x1) ? 10'(s_x2 - s_x1) : 10'(s_x1 - s_x2);
                dy_reg <= (s_y2 > s_y1) ? 10'(s_y2 - s_y1) : 10'(s_y1 - s_y2);
                err_reg <= ((s_x2 > s_x1) ? 10'(s_x2 - s_x1) : 10'(s_x1 - s_x2))
                         - ((s_y2 > s_y1) ? 10'(s_y2 - s_y1) : 10'(s_y1 - s_y2));
                sx_reg <= s_x1 < s_x2;
                sy_reg <= s_y1 < s_y2;
                first_reg <= 1'b1;
                pen_reg <= pen;
            end
            OP_LINE_STEP:
            begin
                if (first_reg)
                    first_reg <= 1'b0;
                else
                begin
                    if (stepx)
                    begin
                        x_reg <= sx_reg ? x_reg + 10'sd1 : x_reg - 10'sd1;
                    end
                    if (stepy)
                    begin
                        y_reg <= sy_reg ? y_reg + 10'sd1 : y_reg - 10'sd1;
                    end
                    err_reg <= err_reg - (stepx ? dy_reg : 10'sd0)
                             + (stepy ? dx_reg : 10'sd0);
                end
            end
            OP_FRECT_LOAD:
            begin
                fx_reg <= x_a;
                fy_reg <= y_a;
                pend_x_reg <= 9'(x_b);
                pend_y_reg <= 9'(y_b);
                pen_reg <= pen;
            end
            OP_PIX_WR:
            begin
                // A filled rectangle moves to its next pixel once this one is written.
                if (func == FN_FRECT)
                begin
                    if (fx_reg == x_b)
                    begin
                        fx_reg <= x_a;
                        fy_reg <= fy_reg + 8'd1;
                    end
                    else
                        fx_reg <= fx_reg + 8'd1;
                end
            end
            OP_PIX_RD:
            begin
                if (func == FN_PIXEL)
                    pen_reg <= pen;
            end
            default: ;
        endcase
    end

    assign rd_byte = q_reg;

endmodule

// File: rtl/bpfde_ctrl.sv
// Command sequencer for the drawing engine; drives the datapath by op codes.
// Depends on bpfde_pkg.
module bpfde_ctrl
    import bpfde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_func,
    output logic [2:0] func,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_sel_read,
    output cmd_t       cmd,
    input  stat_t      stat
);
    state_t state_reg, state_next;
    logic [2:0] func_reg, func_next;
    logic [1:0] seg_reg, seg_next;

    assign func = (state_reg == ST_IDLE) ? in_func : func_reg;
    assign out_sel_read = (func_reg == FN_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            func_reg <= FN_NONE;
            seg_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg <= func_next;
            seg_reg <= seg_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;
        seg_next = seg_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd = '{op: OP_NOP, sweep_val: 1'b0, seg: seg_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_SWEEP_WR;
                if (stat.sweep_last)
                begin
                    func_next = FN_NONE;
                    state_next = ST_OUT;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next = in_func;
                    seg_next = '0;
                    cmd.seg = '0;
                    unique case (func_t'(in_func))
                        FN_FILL:
                        begin
                            cmd.op = OP_CLEAR_ADDR;
                            state_next = ST_FILL;
                        end
                        FN_SCROLL:
                        begin
                            cmd.op = OP_CLEAR_ADDR;
                            state_next = ST_SCROLL_RD;
                        end
                        FN_PIXEL: state_next = ST_PIX_RD;
                        FN_LINE, FN_RECT:
                        begin
                            cmd.op = OP_LINE_LOAD;
                            state_next = ST_LINE_STEP;
                        end
                        FN_FRECT:
                        begin
                            cmd.op = OP_FRECT_LOAD;
                            state_next = stat.frect_empty ? ST_OUT : ST_PIX_RD;
                        end
                        FN_READ: state_next = ST_READ_RD;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.op = OP_SWEEP_WR;
                cmd.sweep_val = 1'b1;
                if (stat.sweep_last)
                    state_next = ST_OUT;
            end
            ST_SCROLL_RD:
            begin
                cmd.op = OP_SCROLL_RD;
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR:
            begin
                cmd.op = OP_SCROLL_WR;
                state_next = stat.scroll_last ? ST_OUT : ST_SCROLL_RD;
            end
            ST_LINE_STEP:
            begin
                // Read the pixel's byte; after the write, ST_LINE_INIT advances the walker.
                cmd.op = OP_PIX_RD;
                state_next = ST_PIX_WR;
            end
            ST_PIX_RD:
            begin
                cmd.op = OP_PIX_RD;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.op = OP_PIX_WR;
                if (func_reg == FN_LINE || func_reg == FN_RECT)
                begin
                    state_next = ST_LINE_INIT;
                end
                else if (func_reg == FN_FRECT)
                begin
                    state_next = ST_OUT;
                    if (!stat.frect_done)
                    begin
                        state_next = ST_PIX_RD;
                    end
                end
                else
                    state_next = ST_OUT;
            end
            ST_LINE_INIT:
            begin
                // Advance the walker, move on to the next segment, or finish the command.
                if (stat.line_done)
                begin
                    if (func_reg == FN_RECT && seg_reg != 2'd3)
                    begin
                        seg_next = seg_reg + 2'd1;
                        cmd.seg = seg_reg + 2'd1;
                        cmd.op = OP_LINE_LOAD;
                        state_next = ST_LINE_STEP;
                    end
                    else
                        state_next = ST_OUT;
                end
                else
                begin
                    cmd.op = OP_LINE_STEP;
                    state_next = ST_LINE_STEP;
                end
            end
            ST_READ_RD:
            begin
                cmd.op = OP_READ_RD;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT: state_next = ST_OUT;
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/band_packed_framebuffer_drawing_engine.sv
// Drawing engine over a band-packed monochrome frame store; one command at a time.
// A read fetches one stored byte; a pixel, each step of a line (an outline walks four lines) and
// each pixel of a filled rectangle read a byte and write it back; an empty filled rectangle goes
// straight to its result; fill and scroll sweep the store. Next command taken in the cycle after
// output. Reset clears all COLUMNS*6 bytes with the input held off; no word is sent for it.
// Depends on bpfde_pkg, bpfde_ctrl, bpfde_datapath.
module band_packed_framebuffer_drawing_engine
    import bpfde_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2:0] func,
    input  logic [7:0] x_a,
    input  logic [7:0] y_a,
    input  logic [7:0] x_b,
    input  logic [7:0] y_b,
    input  logic pen,
    output logic out_valid,
    input  logic out_ready,
    output logic [7:0] read_data
);
    cmd_t cmd;
    stat_t stat;
    logic [2:0] func_cur;
    logic sel_read;
    logic [7:0] rd_byte;
    logic ov;
    logic boot_reg;
    logic [7:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic pen_reg;
    logic [7:0] xa_cur, ya_cur, xb_cur, yb_cur;
    logic pen_cur;

    // The command word is held from acceptance until its result leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xa_reg <= '0;
            ya_reg <= '0;
            xb_reg <= '0;
            yb_reg <= '0;
            pen_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            xa_reg <= x_a;
            ya_reg <= y_a;
            xb_reg <= x_b;
            yb_reg <= y_b;
            pen_reg <= pen;
        end
    end

    assign xa_cur = in_ready ? x_a : xa_reg;
    assign ya_cur = in_ready ? y_a : ya_reg;
    assign xb_cur = in_ready ? x_b : xb_reg;
    assign yb_cur = in_ready ? y_b : yb_reg;
    assign pen_cur = in_ready ? pen : pen_reg;

    bpfde_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .in_func(func), .func(func_cur),
        .out_valid(ov), .out_ready(out_ready || boot_reg), .out_sel_read(sel_read),
        .cmd, .stat
    );

    bpfde_datapath #(.COLUMNS(COLUMNS)) u_dp (
        .clk, .rst_n, .cmd, .stat, .func(func_cur), .x_a(xa_cur), .y_a(ya_cur),
        .x_b(xb_cur), .y_b(yb_cur), .pen(pen_cur), .rd_byte
    );

    // Suppress the output word that ends the post-reset clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boot_reg <= 1'b1;
        else if (ov)
            boot_reg <= 1'b0;
    end

    assign out_valid = ov && !boot_reg;
    assign read_data = (sel_read && 32'(xa_reg) < COLUMNS && ya_reg < 8'(BANDS)) ?
                       rd_byte : 8'h00;

endmodule

// File: sim/band_packed_framebuffer_drawing_engine_test.sv
// Self-checking bench for the band-packed frame store drawing engine.
// It keeps its own copy of the store, predicts each answer and compares it with the result word.
// Depends on bpfde_pkg, bpfde_if and band_packed_framebuffer_drawing_engine.
`timescale 1ns / 100ps

module band_packed_framebuffer_drawing_engine_test;
    import bpfde_pkg::*;

    localparam int NCOL = COLUMNS_DEF;
    localparam int STORE_SIZE = NCOL * BANDS;

    typedef struct packed {
        func_t      func;
        logic [7:0] x_a;
        logic [7:0] y_a;
        logic [7:0] x_b;
        logic [7:0] y_b;
        logic       pen;
    } draw_cmd_t;

    typedef struct packed {
        logic      drain;
        draw_cmd_t cmd;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bpfde_if #(.T(draw_cmd_t)) cmd_ch (clk);
    bpfde_if #(.T(logic [7:0])) res_ch (clk);

    band_packed_framebuffer_drawing_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .in_ready  (cmd_ch.ready),
        .func      (cmd_ch.data.func),
        .x_a       (cmd_ch.data.x_a),
        .y_a       (cmd_ch.data.y_a),
        .x_b       (cmd_ch.data.x_b),
        .y_b       (cmd_ch.data.y_b),
        .pen       (cmd_ch.data.pen),
        .out_valid (res_ch.valid),
        .out_ready (res_ch.ready),
        .read_data (res_ch.data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0] pix_store [0:STORE_SIZE-1];
    pending_t   cmd_queue [$];
    logic [7:0] read_expect [$];
    int         sent_count = 0;
    int         mismatches = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    logic       recv_hold = 1'b0;
    logic       all_queued = 1'b0;

    function automatic void plot(int x, int y, logic clr);
        int idx;
        if (x < 0 || y < 0 || x >= NCOL || y > ROW_MAX)
            return;
        idx = x * BANDS + y / BAND_H;
        if (!clr)
            pix_store[idx] = pix_store[idx] | (8'd1 << (y % BAND_H));
        else
            pix_store[idx] = pix_store[idx] & ~(8'd1 << (y % BAND_H));
    endfunction

    function automatic void trace_line(int x1, int y1, int x2, int y2);
        int dx, dy, sx, sy, err, e2;
        dx = (x2 > x1) ? x2 - x1 : x1 - x2;
        dy = (y2 > y1) ? y2 - y1 : y1 - y2;
        sx = (x1 < x2) ? 1 : -1;
        sy = (y1 < y2) ? 1 : -1;
        err = dx - dy;
        plot(x2, y2, 1'b0);
        while (x1 != x2 || y1 != y2)
        begin
            e2 = err * 2;
            plot(x1, y1, 1'b0);
            if (e2 > -dy)
            begin
                err -= dy;
                x1 += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y1 += sy;
            end
        end
    endfunction

    // Applies one command to the local store and returns the byte the block should answer.
    function automatic logic [7:0] apply_command(draw_cmd_t c);
        int xa, ya, xb, yb;
        logic [7:0] rd;
        rd = 8'd0;
        xa = c.x_a;
        ya = c.y_a;
        xb = c.x_b;
        yb = c.y_b;
        case (c.func)
            FN_FILL:
                for (int i = 0; i < STORE_SIZE; i++)
                    pix_store[i] = c.pen ? 8'hFF : 8'h00;
            FN_SCROLL:
                for (int col = 0; col < NCOL; col++)
                begin
                    for (int b = 0; b < BANDS - 1; b++)
                        pix_store[col * BANDS + b] = pix_store[col * BANDS + b + 1];
                    pix_store[col * BANDS + BANDS - 1] = 8'd0;
                end
            FN_PIXEL:
                plot(xa, ya, c.pen);
            FN_LINE:
                trace_line(xa, ya, xb, yb);
            FN_RECT:
            begin
                trace_line(xa, ya, xb, ya);
                trace_line(xa, yb, xb, yb);
                trace_line(xa, ya, xa, yb);
                trace_line(xb, ya, xb, yb);
            end
            FN_FRECT:
                for (int y = ya; y <= yb; y++)
                    for (int x = xa; x <= xb; x++)
                        plot(x, y, c.pen);
            FN_READ:
                if (xa < NCOL && ya < BANDS)
                    rd = pix_store[xa * BANDS + ya];
            default: ;
        endcase
        return rd;
    endfunction

    function automatic void queue_cmd(func_t f, int xa, int ya, int xb, int yb, logic p,
                                      logic drain = 1'b0);
        pending_t e;
        e.drain = drain;
        e.cmd.func = f;
        e.cmd.x_a = xa[7:0];
        e.cmd.y_a = ya[7:0];
        e.cmd.x_b = xb[7:0];
        e.cmd.y_b = yb[7:0];
        e.cmd.pen = p;
        cmd_queue.push_back(e);
    endfunction

    function automatic int clamp_byte(int v);
        return (v > 255) ? 255 : v;
    endfunction

    // Mostly on-screen coordinates with a margin; now and then any byte value.
    function automatic int pick_x();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 170);
    endfunction

    function automatic int pick_y();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 46);
    endfunction

    function automatic void queue_random_cmd();
        int sel, xa, ya, xb, yb;
        logic p;
        sel = $urandom_range(0, 99);
        xa = pick_x();
        ya = pick_y();
        xb = pick_x();
        yb = pick_y();
        p = 1'($urandom_range(0, 1));
        if (sel < 2)
            queue_cmd(FN_FILL, xa, ya, xb, yb, p);
        else if (sel < 5)
            queue_cmd(FN_SCROLL, xa, ya, xb, yb, p);
        else if (sel < 25)
            queue_cmd(FN_PIXEL, xa, ya, xb, yb, p);
        else if (sel < 37)
        begin
            // Short lines keep the run quick; a few take freely picked end points.
            if ($urandom_range(0, 7) != 0)
            begin
                xb = clamp_byte(xa + $urandom_range(0, 20));
                yb = clamp_byte(ya + $urandom_range(0, 20));
                if ($urandom_range(0, 1)) {xa, xb} = {xb, xa};
                if ($urandom_range(0, 1)) {ya, yb} = {yb, ya};
            end
            queue_cmd(FN_LINE, xa, ya, xb, yb, p);
        end
        else if (sel < 44)
        begin
            xb = clamp_byte(xa + $urandom_range(0, 30));
            yb = clamp_byte(ya + $urandom_range(0, 20));
            if ($urandom_range(0, 3) == 0) {xa, xb} = {xb, xa};
            queue_cmd(FN_RECT, xa, ya, xb, yb, p);
        end
        else if (sel < 56)
        begin
            xb = clamp_byte(xa + $urandom_range(0, 12));
            yb = clamp_byte(ya + $urandom_range(0, 10));
            if ($urandom_range(0, 5) == 0) {xa, xb} = {xb, xa};
            if ($urandom_range(0, 5) == 0) {ya, yb} = {yb, ya};
            if ($urandom_range(0, 299) == 0)
            begin
                xa = $urandom_range(0, 255);
                xb = $urandom_range(0, 255);
                ya = $urandom_range(0, 255);
                yb = $urandom_range(0, 255);
            end
            queue_cmd(FN_FRECT, xa, ya, xb, yb, p);
        end
        else if (sel < 98)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_cmd(FN_READ, $urandom_range(0, 255), $urandom_range(0, 255), xb, yb, p);
            else
                queue_cmd(FN_READ, $urandom_range(0, NCOL - 1), $urandom_range(0, BANDS), xb,
                          yb, p);
        end
        else
            queue_cmd(FN_NONE, xa, ya, xb, yb, p);
    endfunction

    initial
    begin
        for (int i = 0; i < STORE_SIZE; i++)
            pix_store[i] = 8'd0;

        queue_cmd(FN_READ, 0, 0, 0, 0, 1'b0);
        queue_cmd(FN_FILL, 0, 0, 0, 0, 1'b1);
        queue_cmd(FN_READ, NCOL - 1, BANDS - 1, 0, 0, 1'b0);
        queue_cmd(FN_SCROLL, 0, 0, 0, 0, 1'b0);
        queue_cmd(FN_READ, 7, BANDS - 1, 0, 0, 1'b0);
        queue_cmd(FN_READ, 7, BANDS - 2, 0, 0, 1'b0);
        queue_cmd(FN_FILL, 255, 255, 255, 255, 1'b0);
        queue_cmd(FN_PIXEL, 0, 0, 0, 0, 1'b0);
        queue_cmd(FN_PIXEL, NCOL - 1, ROW_MAX, 0, 0, 1'b0);
        queue_cmd(FN_PIXEL, NCOL, 0, 0, 0, 1'b0);
        queue_cmd(FN_PIXEL, 0, ROW_MAX + 1, 0, 0, 1'b0);
        queue_cmd(FN_READ, NCOL - 1, BANDS - 1, 0, 0, 1'b0);
        queue_cmd(FN_LINE, 0, 0, 255, 255, 1'b1);
        queue_cmd(FN_LINE, 255, 0, 0, 255, 1'b0);
        queue_cmd(FN_LINE, 10, 20, 10, 20, 1'b0);
        queue_cmd(FN_RECT, 150, 35, 170, 45, 1'b0);
        queue_cmd(FN_FRECT, 20, 10, 5, 30, 1'b0);
        queue_cmd(FN_FRECT, 5, 30, 20, 10, 1'b0);
        queue_cmd(FN_FRECT, 0, 0, 255, 255, 1'b0);
        queue_cmd(FN_READ, 100, 3, 0, 0, 1'b0);
        queue_cmd(FN_FRECT, 3, 3, 9, 12, 1'b1);
        queue_cmd(FN_READ, 5, 1, 0, 0, 1'b0);
        queue_cmd(FN_READ, NCOL, 0, 0, 0, 1'b0);
        queue_cmd(FN_READ, 0, BANDS, 0, 0, 1'b0);
        queue_cmd(FN_NONE, 255, 255, 255, 255, 1'b1);

        for (int n = 0; n < 1500; n++)
        begin
            queue_random_cmd();
            // Once the sender waits for every outstanding answer before going on.
            if (n == 800)
                cmd_queue[$].drain = 1'b1;
        end
        all_queued = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (all_queued && cmd_queue.size() == 0 && !cmd_ch.valid);
        wait (read_expect.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && read_expect.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Command driver: a word usually waits a random gap before it is offered, but may follow back to back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data <= '0;
            send_gap <= 0;
        end
        else if (cmd_ch.valid && cmd_ch.ready)
        begin
            read_expect.push_back(apply_command(cmd_ch.data));
            sent_count <= sent_count + 1;
            if (cmd_queue.size() != 0 && !cmd_queue[0].drain && $urandom_range(0, 2) == 0)
            begin
                cmd_ch.data <= cmd_queue[0].cmd;
                void'(cmd_queue.pop_front());
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
                send_gap <= $urandom_range(0, 16);
            end
        end
        else if (!cmd_ch.valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (cmd_queue.size() != 0 && (!cmd_queue[0].drain || read_expect.size() == 0))
            begin
                cmd_ch.data <= cmd_queue[0].cmd;
                void'(cmd_queue.pop_front());
                cmd_ch.valid <= 1'b1;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (read_expect.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word read_data=%02h", res_ch.data);
                end
                else if (res_ch.data !== read_expect[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("read_data mismatch: expected %02h, got %02h",
                                 read_expect[0], res_ch.data);
                    void'(read_expect.pop_front());
                end
                else
                    void'(read_expect.pop_front());
                if ($urandom_range(0, 2) == 0)
                    recv_gap <= 0;
                else
                    recv_gap <= $urandom_range(0, 16);
                res_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= !recv_hold;
        end
    end

    // A long receiver hold-off so the engine backs up and stalls its command input.
    initial
    begin
        wait (sent_count >= 400);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold <= 1'b0;
    end

    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
